// File: hdl/xpfc_pkg.sv
// ----------------------------------------------------------------------------
// xpfc_pkg
// Shared types and constants of the packet frame checker.
// ----------------------------------------------------------------------------
package xpfc_pkg;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 1'd1;

    localparam logic [BYTE_W-1:0] HEADER_RESET      = 8'd170;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd32;

    localparam logic [BYTE_W-1:0] MIN_FRAME_BYTES = 8'd4;
    localparam logic [BYTE_W-1:0] PAYLOAD_START   = 8'd3;
    localparam logic [BYTE_W-1:0] POS_SATURATED   = 8'd255;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEN_LARGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CSUM      = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   payload_index;
        logic [BYTE_W-1:0]   command;
        logic [BYTE_W-1:0]   payload_length;
        logic [STATUS_W-1:0] status;
        logic                packet_ok;
    } result_t;

endpackage

// File: hdl/xor_packet_frame_checker.sv
// ----------------------------------------------------------------------------
// xor_packet_frame_checker
// Byte-stream packet parser with header, length and XOR checksum checks.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata = rx_byte, s_tlast = end_of_buffer
//   m_*      out  m_tvalid/m_tready  m_tdata = result fields, m_tuser = kind
//   cfg_*    in   cfg_wr_en          cfg_addr = register index, cfg_data
//
// One byte per cycle while m_tready does not stall; each byte passes the
// input register, then the result register behind the parser logic. A
// byte that yields no result only updates the frame state. Stalls on
// m_tready hold the result register and back up into the input
// register. Reset clears the frame state and loads the register defaults.
// ----------------------------------------------------------------------------
module xor_packet_frame_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [39:0]                    m_tdata,   // data, payload_index, command,
                                                      // payload_length, status,
                                                      // packet_ok, zero pad
    output logic                           m_tuser,   // kind
    input  logic                           cfg_wr_en,
    input  logic [xpfc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [xpfc_pkg::BYTE_W-1:0]    cfg_data
);

    logic [xpfc_pkg::BYTE_W-1:0] header_reg;
    logic [xpfc_pkg::BYTE_W-1:0] max_pay_reg;

    logic                        in_valid_reg;
    logic [xpfc_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;

    xpfc_pkg::result_t           res;
    xpfc_pkg::result_t           out_reg;
    logic                        out_valid_reg;
    logic                        adv;
    logic                        step;

    assign adv      = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= xpfc_pkg::HEADER_RESET;
            max_pay_reg <= xpfc_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                xpfc_pkg::REG_HEADER_VALUE: header_reg  <= cfg_data;
                xpfc_pkg::REG_MAX_PAYLOAD:  max_pay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    xpfc_frame_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .end_of_buffer (in_last_reg),
        .header_value  (header_reg),
        .max_payload   (max_pay_reg),
        .result        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && res.valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {4'd0, out_reg.packet_ok, out_reg.status, out_reg.payload_length,
                       out_reg.command, out_reg.payload_index, out_reg.data};

`ifndef SYNTH
    a_ok_means_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.packet_ok) |-> (out_reg.status == xpfc_pkg::ST_OK))
        else $error("packet_ok set with nonzero status");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == xpfc_pkg::KIND_PAYLOAD))
            |-> (out_reg.status == xpfc_pkg::ST_OK && !out_reg.packet_ok))
        else $error("payload result carries verdict fields");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while result register empty");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a request during stall");
`endif

endmodule

// File: hdl/xpfc_frame_parser.sv
// ----------------------------------------------------------------------------
// xpfc_frame_parser
// Per-buffer frame state and the result logic for one received byte.
// ----------------------------------------------------------------------------
module xpfc_frame_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [xpfc_pkg::BYTE_W-1:0] rx_byte,
    input  logic                      end_of_buffer,
    input  logic [xpfc_pkg::BYTE_W-1:0] header_value,
    input  logic [xpfc_pkg::BYTE_W-1:0] max_payload,
    output xpfc_pkg::result_t         result
);

    logic [xpfc_pkg::BYTE_W-1:0] pos_reg, pos_next;
    logic                        hdr_ok_reg, hdr_ok_next;
    logic [xpfc_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    logic [xpfc_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [xpfc_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [xpfc_pkg::BYTE_W-1:0] csum_reg, csum_next;

    logic [xpfc_pkg::BYTE_W:0]   csum_pos;
    logic [xpfc_pkg::BYTE_W:0]   need_count;
    logic                        emit_payload;
    logic [xpfc_pkg::STATUS_W-1:0] status;

    assign csum_pos   = {1'b0, len_reg} + {1'b0, xpfc_pkg::PAYLOAD_START};
    assign need_count = {1'b0, len_next} + {1'b0, xpfc_pkg::MIN_FRAME_BYTES};

    always_comb
    begin
        pos_next     = pos_reg;
        hdr_ok_next  = hdr_ok_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        xor_next     = xor_reg;
        csum_next    = csum_reg;
        emit_payload = 1'b0;
        if (pos_reg != xpfc_pkg::POS_SATURATED)
        begin
            if (pos_reg == 8'd0)
            begin
                hdr_ok_next = (rx_byte == header_value);
            end
            else if (pos_reg == 8'd1)
            begin
                cmd_next = rx_byte;
                xor_next = rx_byte;
            end
            else if (pos_reg == 8'd2)
            begin
                len_next = rx_byte;
                xor_next = xor_reg ^ rx_byte;
            end
            else if ({1'b0, pos_reg} < csum_pos)
            begin
                xor_next     = xor_reg ^ rx_byte;
                emit_payload = hdr_ok_reg && (len_reg <= max_payload);
            end
            else if ({1'b0, pos_reg} == csum_pos)
            begin
                csum_next = rx_byte;
            end
            pos_next = pos_reg + 8'd1;
        end
    end

    always_comb
    begin
        if (pos_next < xpfc_pkg::MIN_FRAME_BYTES)
            status = xpfc_pkg::ST_SHORT;
        else if (!hdr_ok_next)
            status = xpfc_pkg::ST_BAD_HDR;
        else if (len_next > max_payload)
            status = xpfc_pkg::ST_LEN_LARGE;
        else if ({1'b0, pos_next} < need_count)
            status = xpfc_pkg::ST_TRUNC;
        else if (csum_next != xor_next)
            status = xpfc_pkg::ST_CSUM;
        else
            status = xpfc_pkg::ST_OK;
    end

    always_comb
    begin
        result.valid          = step && (end_of_buffer || emit_payload);
        result.command        = cmd_next;
        result.payload_length = len_next;
        if (end_of_buffer)
        begin
            result.kind          = xpfc_pkg::KIND_VERDICT;
            result.data          = csum_next;
            result.payload_index = '0;
            result.status        = status;
            result.packet_ok     = (status == xpfc_pkg::ST_OK);
        end
        else
        begin
            result.kind          = xpfc_pkg::KIND_PAYLOAD;
            result.data          = rx_byte;
            result.payload_index = pos_reg - xpfc_pkg::PAYLOAD_START;
            result.status        = xpfc_pkg::ST_OK;
            result.packet_ok     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b0;
            cmd_reg    <= '0;
            len_reg    <= '0;
            xor_reg    <= '0;
            csum_reg   <= '0;
        end
        else if (step)
        begin
            if (end_of_buffer)
            begin
                pos_reg    <= '0;
                hdr_ok_reg <= 1'b0;
                cmd_reg    <= '0;
                len_reg    <= '0;
                xor_reg    <= '0;
                csum_reg   <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                hdr_ok_reg <= hdr_ok_next;
                cmd_reg    <= cmd_next;
                len_reg    <= len_next;
                xor_reg    <= xor_next;
                csum_reg   <= csum_next;
            end
        end
    end

endmodule
